@@ rtl/core/siphash_2_4_keyed_hash_top_assert.svh @@
// Assertion macros for the SipHash-2-4 top level.
// Used by siphash_2_4_keyed_hash_top; needs nothing else.
`ifndef SIPHASH_2_4_KEYED_HASH_TOP_ASSERT_SVH
`define SIPHASH_2_4_KEYED_HASH_TOP_ASSERT_SVH

// same-cycle implication
`define SH24_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("sh24 same-cycle check failed");

// next-cycle implication
`define SH24_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("sh24 next-cycle check failed");

`endif

@@ rtl/core/sh24_pkg.sv @@
// Shared types, constants and helpers for the SipHash-2-4 core.
// No dependencies; imported by every module of the block.
package sh24_pkg;

  localparam logic [63:0] INIT_C0 = 64'h736F6D6570736575;
  localparam logic [63:0] INIT_C1 = 64'h646F72616E646F6D;
  localparam logic [63:0] INIT_C2 = 64'h6C7967656E657261;
  localparam logic [63:0] INIT_C3 = 64'h7465646279746573;
  localparam logic [63:0] FIN_XOR = 64'h0000_0000_0000_00FF;

  localparam int          FINAL_ROUNDS = 4;
  localparam int          RND_W        = $clog2(FINAL_ROUNDS);
  localparam logic [RND_W-1:0] LAST_RND = RND_W'(FINAL_ROUNDS - 1);

  localparam logic [3:0]  FULL_BYTES = 4'd8;

  localparam logic        REG_KEY_LOW  = 1'b0;
  localparam logic        REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sh24_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sh24_status_t;

  function automatic logic [63:0] mask_bytes(input logic [63:0] d, input logic [3:0] nb);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nb) begin
        r[8*i +: 8] = d[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/sh24_round.sv @@
// One SipRound over the four 64-bit state words.
// Depends on sh24_pkg for the state type.
module sh24_round (
  input  sh24_pkg::sh24_state_t vin,
  output sh24_pkg::sh24_state_t vout
);
  import sh24_pkg::*;

  logic [63:0] a0, a2, b1, b3, c0, c2, c0b, d1, d3, d2;

  always_comb begin
    a0  = vin.v0 + vin.v1;
    a2  = vin.v2 + vin.v3;
    b1  = {vin.v1[50:0], vin.v1[63:51]} ^ a0;
    b3  = {vin.v3[47:0], vin.v3[63:48]} ^ a2;
    c0  = {a0[31:0], a0[63:32]};
    c2  = a2 + b1;
    c0b = c0 + b3;
    d1  = {b1[46:0], b1[63:47]} ^ c2;
    d3  = {b3[42:0], b3[63:43]} ^ c0b;
    d2  = {c2[31:0], c2[63:32]};
    vout.v0 = c0b;
    vout.v1 = d1;
    vout.v2 = d2;
    vout.v3 = d3;
  end

endmodule

@@ rtl/core/sh24_core.sv @@
// SipHash state registers and the sequencer that drives the shared round unit.
// Depends on sh24_pkg and sh24_round.
module sh24_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [63:0]            block_data,
  input  logic [3:0]             valid_bytes,
  input  logic                   is_last,
  input  logic [63:0]            key_low,
  input  logic [63:0]            key_high,
  input  logic                   hold,
  output sh24_pkg::sh24_status_t status,
  output logic [63:0]            digest
);
  import sh24_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_C1   = 2'd1;
  localparam logic [1:0] ST_C2   = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       state;
  sh24_state_t      v;
  logic [7:0]       byte_count;
  logic             in_message;
  logic [63:0]      msg;
  logic [63:0]      fin_word;
  logic             fin_pending;
  logic             final_blk;
  logic [RND_W-1:0] rnd_cnt;

  sh24_state_t base, rin, rout, v_c2;
  logic [7:0]  base_bc, bc_next;
  logic        full;
  logic [3:0]  nb;
  logic [63:0] m_in;

  always_comb begin
    base.v0 = key_low  ^ INIT_C0;
    base.v1 = key_high ^ INIT_C1;
    base.v2 = key_low  ^ INIT_C2;
    base.v3 = key_high ^ INIT_C3;
    base_bc = '0;
    if (in_message) begin
      base    = v;
      base_bc = byte_count;
    end
    full    = !is_last || (valid_bytes >= FULL_BYTES);
    nb      = full ? FULL_BYTES : valid_bytes;
    bc_next = base_bc + {4'd0, nb};
    m_in    = full ? block_data : (mask_bytes(block_data, nb) | {bc_next, 56'd0});
    case (state)
      ST_IDLE: begin
        rin    = base;
        rin.v3 = base.v3 ^ m_in;
      end
      ST_C1: begin
        rin    = v;
        rin.v3 = v.v3 ^ msg;
      end
      default: rin = v;
    endcase
  end

  sh24_round u_round (
    .vin  (rin),
    .vout (rout)
  );

  always_comb begin
    v_c2    = rout;
    v_c2.v0 = rout.v0 ^ msg;
    if (!fin_pending && final_blk) begin
      v_c2.v2 = rout.v2 ^ FIN_XOR;
    end
  end

  assign digest      = rout.v0 ^ rout.v1 ^ rout.v2 ^ rout.v3;
  assign status.busy = (state != ST_IDLE);
  assign status.done = (state == ST_FIN) && (rnd_cnt == LAST_RND) && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      v           <= '0;
      byte_count  <= '0;
      in_message  <= 1'b0;
      fin_pending <= 1'b0;
      final_blk   <= 1'b0;
      rnd_cnt     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            v           <= rout;
            msg         <= m_in;
            fin_word    <= {bc_next, 56'd0};
            byte_count  <= bc_next;
            in_message  <= 1'b1;
            fin_pending <= is_last && full;
            final_blk   <= is_last;
            state       <= ST_C2;
          end
        end
        ST_C1: begin
          v     <= rout;
          state <= ST_C2;
        end
        ST_C2: begin
          v <= v_c2;
          if (fin_pending) begin
            msg         <= fin_word;
            fin_pending <= 1'b0;
            state       <= ST_C1;
          end else if (final_blk) begin
            rnd_cnt <= '0;
            state   <= ST_FIN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_FIN: begin
          if (rnd_cnt != LAST_RND) begin
            v       <= rout;
            rnd_cnt <= rnd_cnt + 1'b1;
          end else if (!hold) begin
            v          <= rout;
            in_message <= 1'b0;
            final_blk  <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/siphash_2_4_keyed_hash_top.sv @@
// Top level of the SipHash-2-4 keyed hash: key registers, handshakes, result register.
// Depends on sh24_pkg, sh24_core and the assertion macro header.

// One SipRound unit is reused every cycle, so a non-last 64-bit word runs its
// 2 compression rounds (ST_IDLE, ST_C2) before the next word can be taken. A last
// word of fewer than 8 bytes runs 2 compression and 4 finalization rounds; a full
// 8-byte last word also runs the compression rounds of a second block holding the
// length. The hash is then held in an output register while the next message is
// already being taken. The key is sampled when the first word of a message is
// accepted, so key writes take effect with the next message.
`include "siphash_2_4_keyed_hash_top_assert.svh"

module siphash_2_4_keyed_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] block_data,
  input  logic [3:0]  valid_bytes,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] hash,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import sh24_pkg::*;

  logic [63:0]  key_low;
  logic [63:0]  key_high;
  sh24_status_t status;
  logic [63:0]  digest;
  logic         hold;
  logic         start;

  assign cfg_ready = 1'b1;
  assign in_stall  = status.busy;
  assign start     = in_valid && !in_stall;
  assign hold      = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  sh24_core u_core (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .block_data  (block_data),
    .valid_bytes (valid_bytes),
    .is_last     (is_last),
    .key_low     (key_low),
    .key_high    (key_high),
    .hold        (hold),
    .status      (status),
    .digest      (digest)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      hash <= digest;
    end
  end

  `SH24_ASSERT_NXT(a_accept_busy, clk, rst, start, in_stall)
  `SH24_ASSERT_IMP(a_done_free, clk, rst, status.done, !hold)
  `SH24_ASSERT_NXT(a_done_result, clk, rst, status.done, out_valid && !in_stall)

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for siphash_2_4_keyed_hash_top: keyed SipHash-2-4 over word streams.
// Predicts every hash in a local SipHash model and checks each hash item in order.
// Depends on sh24_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
  import sh24_pkg::*;

  localparam logic [63:0] SIP_C0 = 64'h736F6D6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646F72616E646F6D;
  localparam logic [63:0] SIP_C2 = 64'h6C7967656E657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 20;
  localparam int          LONG_HOLD      = 300;
  localparam int          RANDOM_WORDS   = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] block_data = '0;
  logic [3:0]  valid_bytes = '0;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] hash;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_KEY_LOW;
  logic [63:0] cfg_data = '0;

  logic [63:0] key_lo_shadow = '0;
  logic [63:0] key_hi_shadow = '0;
  logic [63:0] hs_v0, hs_v1, hs_v2, hs_v3;
  logic [7:0]  hs_len = '0;
  logic        hs_open = 1'b0;
  logic [63:0] hash_expect_q[$];
  logic [63:0] expected_hash;

  bit in_gaps_on  = 1'b1;
  bit out_gaps_on = 1'b1;
  int hold_len    = 0;
  int stall_left  = 0;
  int idle_cycles = 0;
  int errors      = 0;
  int words_sent  = 0;
  int hashes_seen = 0;
  int key_writes  = 0;

  siphash_2_4_keyed_hash_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .block_data(block_data), .valid_bytes(valid_bytes), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall), .hash(hash),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic void sip_round();
    hs_v0 = hs_v0 + hs_v1;
    hs_v2 = hs_v2 + hs_v3;
    hs_v1 = rotl64(hs_v1, 13);
    hs_v3 = rotl64(hs_v3, 16);
    hs_v1 = hs_v1 ^ hs_v0;
    hs_v3 = hs_v3 ^ hs_v2;
    hs_v0 = rotl64(hs_v0, 32);
    hs_v2 = hs_v2 + hs_v1;
    hs_v0 = hs_v0 + hs_v3;
    hs_v1 = rotl64(hs_v1, 17);
    hs_v3 = rotl64(hs_v3, 21);
    hs_v1 = hs_v1 ^ hs_v2;
    hs_v3 = hs_v3 ^ hs_v0;
    hs_v2 = rotl64(hs_v2, 32);
  endfunction

  function automatic void absorb_block(input logic [63:0] m);
    hs_v3 = hs_v3 ^ m;
    sip_round();
    sip_round();
    hs_v0 = hs_v0 ^ m;
  endfunction

  function automatic void predict_hash(input logic [63:0] d, input logic [3:0] nb,
                                       input logic last);
    logic [3:0]  n;
    logic [63:0] fin;
    if (!hs_open) begin
      hs_v0   = key_lo_shadow ^ SIP_C0;
      hs_v1   = key_hi_shadow ^ SIP_C1;
      hs_v2   = key_lo_shadow ^ SIP_C2;
      hs_v3   = key_hi_shadow ^ SIP_C3;
      hs_len  = '0;
      hs_open = 1'b1;
    end
    if (!last) begin
      absorb_block(d);
      hs_len = hs_len + 8'd8;
      return;
    end
    n = (nb > 4'd8) ? 4'd8 : nb;
    if (n == 4'd8) begin
      absorb_block(d);
      hs_len = hs_len + 8'd8;
      fin = {hs_len, 56'h0};
    end else begin
      hs_len = hs_len + 8'(n);
      fin = (d & ((64'h1 << (8 * n)) - 64'h1)) | {hs_len, 56'h0};
    end
    absorb_block(fin);
    hs_v2 = hs_v2 ^ 64'hFF;
    repeat (4) sip_round();
    hash_expect_q.push_back(hs_v0 ^ hs_v1 ^ hs_v2 ^ hs_v3);
    hs_open = 1'b0;
  endfunction

  // sender: called at a rising edge, returns at the edge the item is taken
  task automatic send_word(input logic [63:0] d, input logic [3:0] nb, input logic last);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    block_data  <= d;
    valid_bytes <= nb;
    is_last     <= last;
    do @(posedge clk); while (in_stall);
    predict_hash(d, nb, last);
    words_sent++;
  endtask

  // hold input until every hash is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (hash_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_KEY_LOW) key_lo_shadow = val;
    else key_hi_shadow = val;
    key_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_key(input logic [63:0] lo, input logic [63:0] hi);
    drain();
    write_reg(REG_KEY_LOW, lo);
    write_reg(REG_KEY_HIGH, hi);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_key();
    int sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return rand64();
  endfunction

  task automatic send_message(input int body_words, input logic [3:0] last_nb);
    logic [3:0] nb;
    for (int i = 0; i < body_words; i++) begin
      nb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      send_word(rand64(), nb, 1'b0);
    end
    send_word(rand64(), last_nb, 1'b1);
  endtask

  task automatic test_reset_key();
    send_word('1, 4'd0, 1'b1);
    send_word(rand64(), 4'd8, 1'b1);
    set_key('1, '1);
    send_word('1, 4'd8, 1'b1);
    send_word('0, 4'd8, 1'b1);
  endtask

  task automatic test_edge_words();
    set_key(64'h0706050403020100, 64'h0F0E0D0C0B0A0908);
    send_word(64'h0706050403020100, 4'd8, 1'b0);
    send_word(64'hFF0E0D0C0B0A0908, 4'd7, 1'b1);
    for (int n = 1; n < 8; n++) send_word('1, 4'(n), 1'b1);
    send_word(rand64(), 4'd9, 1'b1);
    send_word(rand64(), 4'd15, 1'b1);
    send_word(rand64(), 4'd3, 1'b0);
    send_word(rand64(), 4'd0, 1'b1);
  endtask

  task automatic test_key_mid_message();
    send_word(rand64(), 4'd8, 1'b0);
    set_key(rand64(), rand64());
    send_word(rand64(), 4'd8, 1'b0);
    send_word(rand64(), 4'd5, 1'b1);
    send_word(rand64(), 4'd5, 1'b1);
  endtask

  task automatic test_length_wrap();
    send_message(32, 4'd5);
    send_message(33, 4'd8);
  endtask

  task automatic test_backpressure();
    drain();
    in_gaps_on = 1'b0;
    hold_len   = LONG_HOLD;
    for (int i = 0; i < 20; i++) send_message($urandom_range(0, 2), 4'($urandom_range(0, 8)));
    drain();
    in_gaps_on = 1'b1;
  endtask

  task automatic test_random_messages();
    int target;
    int sel;
    int body;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      if ($urandom_range(0, 3) == 0) set_key(pick_key(), pick_key());
      in_gaps_on  = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      repeat (8) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) body = $urandom_range(0, 3);
        else if (sel < 95) body = $urandom_range(4, 12);
        else body = $urandom_range(30, 36);
        if ($urandom_range(0, 9) < 7) send_message(body, 4'($urandom_range(0, 8)));
        else send_message(body, 4'($urandom_range(0, 15)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      hashes_seen++;
      if (hash_expect_q.size() == 0) begin
        $display("%0t: unexpected hash, expected none actual %h", $time, hash);
        errors++;
      end else begin
        expected_hash = hash_expect_q.pop_front();
        if (hash !== expected_hash) begin
          $display("%0t: hash mismatch expected %h actual %h", $time, expected_hash, hash);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        stall_left = hold_len;
        hold_len   = 0;
      end else if (out_valid && !out_stall) begin
        stall_left = out_gaps_on ? $urandom_range(0, 14) : 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d hashes pending", $time, hash_expect_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key();
    test_edge_words();
    test_key_mid_message();
    test_length_wrap();
    test_backpressure();
    test_random_messages();
    drain();
    if (hash_expect_q.size() != 0) begin
      $display("%0t: %0d expected hashes never arrived", $time, hash_expect_q.size());
      errors++;
    end
    $display("Sent %0d words, checked %0d hashes across %0d key writes.",
             words_sent, hashes_seen, key_writes);
    $display("Covered empty, partial, full and oversized last words, key change",
             " mid-message, length wrap and full backpressure.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
